>>> rtl/rdsg_pkg.sv
// shared constants, types and codes of the rds group decoder
`default_nettype none

package rdsg_pkg;

	// text store geometry: 64 bytes held as 16 words of four bytes
	localparam int TEXT_BYTES = 64;
	localparam int TEXT_WORDS = TEXT_BYTES / 4;
	localparam int WORD_AW    = $clog2(TEXT_WORDS);

	localparam logic [7:0] CR_CHAR  = 8'h0D;
	localparam logic [6:0] FULL_LEN = 7'(TEXT_BYTES);
	localparam int         ZONE_STEP = 30;

	// group types handled
	localparam logic [3:0] GT_NAME  = 4'd0;
	localparam logic [3:0] GT_TEXT  = 4'd2;
	localparam logic [3:0] GT_CLOCK = 4'd4;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_TEXT   = 2'd1;
	localparam logic [1:0] KIND_CLOCK  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STATUS,
		ST_EMIT,
		ST_CLOCK
	} state_t;

	// write request into the text store, byte lane j is bits [31-8j -: 8]
	typedef struct packed {
		logic               en;
		logic               clear;
		logic [WORD_AW-1:0] word;
		logic [3:0]         be;
		logic [31:0]        data;
	} ts_wr_t;

endpackage

`default_nettype wire

>>> rtl/rdsg_if.sv
// request channels of the rds group decoder: group input and result output
`default_nettype none

interface rdsg_grp_if;
	logic        valid;
	logic        ready;
	logic [15:0] block_a;
	logic [15:0] block_b;
	logic [15:0] block_c;
	logic [15:0] block_d;

	modport source (output valid, block_a, block_b, block_c, block_d, input ready);
	modport sink   (input valid, block_a, block_b, block_c, block_d, output ready);
endinterface

interface rdsg_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [15:0]        pi_code;
	logic [4:0]         program_type;
	logic [2:0]         status_flags;
	logic [63:0]        station_name;
	logic [31:0]        text_chunk;
	logic [6:0]         text_length;
	logic [16:0]        day_number;
	logic [10:0]        hour_minute;
	logic signed [10:0] zone_offset;
	logic               last;

	modport source (output valid, kind, pi_code, program_type, status_flags, station_name,
		text_chunk, text_length, day_number, hour_minute, zone_offset, last, input ready);
	modport sink   (input valid, kind, pi_code, program_type, status_flags, station_name,
		text_chunk, text_length, day_number, hour_minute, zone_offset, last, output ready);
endinterface

`default_nettype wire

>>> rtl/rdsg_text_store.sv
// radiotext store: 16x32 memory with byte writes, per-byte valid bits, registered read
`default_nettype none

module rdsg_text_store import rdsg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ts_wr_t             wr,
	input  wire logic               rd_en,
	input  wire logic [WORD_AW-1:0] rd_word,
	output logic      [31:0]        rd_data
);

	logic [31:0] mem_q [TEXT_WORDS];
	logic [3:0]  valid_q [TEXT_WORDS];
	logic [31:0] raw_s1;
	logic [3:0]  vmask_s1;

	// byte-lane writes into the memory
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int j = 0; j < 4; j++) begin
				if (wr.be[j]) begin
					mem_q[wr.word][31-8*j -: 8] <= wr.data[31-8*j -: 8];
				end
			end
		end
	end

	// valid bits: a clear drops every byte, a write marks its lanes
	always_ff @(posedge clk or negedge arst_n) begin
		logic [3:0] vnext;
		if (!arst_n) begin
			for (int w = 0; w < TEXT_WORDS; w++) begin
				valid_q[w] <= '0;
			end
		end else begin
			for (int w = 0; w < TEXT_WORDS; w++) begin
				vnext = wr.clear ? 4'b0000 : valid_q[w];
				if (wr.en && (wr.word == WORD_AW'(w))) begin
					vnext = vnext | wr.be;
				end
				valid_q[w] <= vnext;
			end
		end
	end

	// registered read of data and lane valids
	always_ff @(posedge clk) begin
		if (rd_en) begin
			raw_s1   <= mem_q[rd_word];
			vmask_s1 <= valid_q[rd_word];
		end
	end

	// bytes never written since the last clear read as zero
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			rd_data[31-8*j -: 8] = vmask_s1[j] ? raw_s1[31-8*j -: 8] : 8'h00;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rdsg_clock_unpack.sv
// unpacks the clock time fields of group 4a
`default_nettype none

module rdsg_clock_unpack import rdsg_pkg::*; (
	input  wire logic [15:0]        block_b,
	input  wire logic [15:0]        block_c,
	input  wire logic [15:0]        block_d,
	output logic      [16:0]        day_number,
	output logic      [10:0]        hour_minute,
	output logic signed [10:0]      zone_offset
);

	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [10:0] zone_mag;

	// day number spans block b bits 1:0 and block c bits 15:1
	assign day_number  = {block_b[1:0], block_c[15:1]};

	// hour and minute
	assign hour        = {block_c[0], block_d[15:12]};
	assign minute      = {block_d[11:8], block_d[7:6]};
	assign hour_minute = {hour, minute};

	// offset in half hours scaled to minutes, sign from bit 5
	assign zone_mag    = 11'(block_d[4:0]) * 11'(ZONE_STEP);
	assign zone_offset = block_d[5] ? -$signed(zone_mag) : $signed(zone_mag);

endmodule

`default_nettype wire

>>> rtl/rds_group_decoder.sv
// rds group decoder top level: group decode, text scan and result sequencing
//
//  channel | dir | content                               | item
//  grp     | in  | block_a .. block_d                    | one rds group
//  res     | out | kind, pi, pty, flags, name, text/time | status, text chunk or clock
//
//  A group is taken only while the sequencer is idle; the store and flag updates
//  happen at the accept edge. Every group gives a status result; group 4a adds a
//  clock result. Radiotext first scans the store one 32-bit word per cycle, set by
//  its single read port, then gives the status result and the text chunks, one chunk
//  per cycle while the output is not stalled. Reset clears the store's valid bits
//  at once, no clearing pass. A stalled output holds the sequencer in place.
`default_nettype none

module rds_group_decoder import rdsg_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	rdsg_grp_if.sink   grp,
	rdsg_res_if.source res
);

	state_t state_q, state_nx;

	// decoded station state
	logic       ta_q;
	logic       music_q;
	logic       ab_q;
	logic [7:0] name_q [8];
	logic [63:0] name_flat;

	// held group fields
	logic [15:0] pi_q;
	logic [15:0] bb_q;
	logic [15:0] bc_q;
	logic [15:0] bd_q;
	logic        is_clock;
	logic        end_full;

	// text scan and emit bookkeeping
	logic [WORD_AW:0]   scan_k_q;
	logic [WORD_AW:0]   emit_k_q;
	logic               rd_vld_s1;
	logic [WORD_AW-1:0] rd_word_s1;
	logic               emit_text_q;
	logic [6:0]         text_len_q;
	logic [WORD_AW-1:0] last_chunk_q;

	// store ports
	ts_wr_t             wr;
	logic               rd_en;
	logic [WORD_AW-1:0] rd_word;
	logic [31:0]        rd_data;

	// byte checks on the word just read
	logic [3:0] cr_hit;
	logic       cr_any;
	logic [1:0] cr_lane;
	logic [5:0] cr_pos;
	logic       scan_done;
	logic [6:0] len_nx;
	logic [6:0] len_m1;
	logic [31:0] chunk_word;

	// clock fields
	logic [16:0]        clk_day;
	logic [10:0]        clk_hm;
	logic signed [10:0] clk_zone;

	// output register
	logic               out_vld_q;
	logic               out_free;
	logic               out_load;
	logic [1:0]         kind_q, kind_nx;
	logic [15:0]        pi_out_q;
	logic [4:0]         pty_q;
	logic [2:0]         sflags_q;
	logic [63:0]        name_out_q;
	logic [31:0]        chunk_q, chunk_nx;
	logic [6:0]         tlen_q, tlen_nx;
	logic [16:0]        day_q, day_nx;
	logic [10:0]        hm_q, hm_nx;
	logic signed [10:0] zone_q, zone_nx;
	logic               last_q, last_nx;

	logic acc;
	logic in_text;

	assign acc       = grp.valid && grp.ready;
	assign grp.ready = (state_q == ST_IDLE);
	assign in_text   = (grp.block_b[15:12] == GT_TEXT);

	assign is_clock  = (bb_q[15:12] == GT_CLOCK) && !bb_q[11];
	assign end_full  = !bb_q[11] && (bb_q[3:0] == 4'hF);

	// text store write request from the incoming group
	always_comb begin
		wr.en    = acc && in_text;
		wr.clear = acc && in_text && (grp.block_b[4] != ab_q);
		if (grp.block_b[11]) begin
			wr.word = WORD_AW'(grp.block_b[3:1]);
			wr.be   = grp.block_b[0] ? 4'b1100 : 4'b0011;
			wr.data = {grp.block_d, grp.block_d};
		end else begin
			wr.word = grp.block_b[3:0];
			wr.be   = 4'b1111;
			wr.data = {grp.block_c, grp.block_d};
		end
	end

	rdsg_text_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_word (rd_word),
		.rd_data (rd_data)
	);

	rdsg_clock_unpack u_clock (
		.block_b     (bb_q),
		.block_c     (bc_q),
		.block_d     (bd_q),
		.day_number  (clk_day),
		.hour_minute (clk_hm),
		.zone_offset (clk_zone)
	);

	// flags, a/b toggle and station name update at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ta_q    <= 1'b0;
			music_q <= 1'b1;
			ab_q    <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				name_q[i] <= 8'h00;
			end
		end else if (acc) begin
			if (grp.block_b[15:12] == GT_NAME) begin
				ta_q    <= grp.block_b[4];
				music_q <= grp.block_b[3];
				name_q[{grp.block_b[1:0], 1'b0}] <= grp.block_d[15:8];
				name_q[{grp.block_b[1:0], 1'b1}] <= grp.block_d[7:0];
			end
			if (in_text) begin
				ab_q <= grp.block_b[4];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			name_flat[63-8*i -: 8] = name_q[i];
		end
	end

	// hold the group fields for the sequencer
	always_ff @(posedge clk) begin
		if (acc) begin
			pi_q <= grp.block_a;
			bb_q <= grp.block_b;
			bc_q <= grp.block_c;
			bd_q <= grp.block_d;
		end
	end

	// first carriage return in the word under test
	always_comb begin
		cr_lane = 2'd0;
		for (int j = 0; j < 4; j++) begin
			cr_hit[j] = (rd_data[31-8*j -: 8] == CR_CHAR);
		end
		for (int j = 3; j >= 0; j--) begin
			if (cr_hit[j]) begin
				cr_lane = 2'(j);
			end
		end
		cr_any    = |cr_hit;
		cr_pos    = {rd_word_s1, cr_lane};
		scan_done = (state_q == ST_SCAN) && rd_vld_s1 &&
			(cr_any || (rd_word_s1 == WORD_AW'(TEXT_WORDS - 1)));
		len_nx    = cr_any ? 7'(cr_pos) : FULL_LEN;
		len_m1    = len_nx - 7'd1;
	end

	// chunk bytes past the message end read as zero
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			chunk_word[31-8*j -: 8] = ({1'b0, rd_word_s1, 2'(j)} < text_len_q) ?
				rd_data[31-8*j -: 8] : 8'h00;
		end
	end

	assign out_free = !out_vld_q || res.ready;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) state_nx = in_text ? ST_SCAN : ST_STATUS;
			end
			ST_SCAN: begin
				if (scan_done) state_nx = ST_STATUS;
			end
			ST_STATUS: begin
				if (out_free) begin
					if (emit_text_q)   state_nx = ST_EMIT;
					else if (is_clock) state_nx = ST_CLOCK;
					else               state_nx = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (rd_vld_s1 && out_free && (rd_word_s1 == last_chunk_q)) state_nx = ST_IDLE;
			end
			ST_CLOCK: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// per-state reads and result selection
	always_comb begin
		rd_en    = 1'b0;
		rd_word  = scan_k_q[WORD_AW-1:0];
		out_load = 1'b0;
		kind_nx  = KIND_STATUS;
		chunk_nx = '0;
		tlen_nx  = '0;
		day_nx   = '0;
		hm_nx    = '0;
		zone_nx  = '0;
		last_nx  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_SCAN: begin
				rd_en = !scan_k_q[WORD_AW];
			end
			ST_STATUS: begin
				out_load = out_free;
				last_nx  = !emit_text_q && !is_clock;
			end
			ST_EMIT: begin
				rd_word  = emit_k_q[WORD_AW-1:0];
				rd_en    = (emit_k_q <= {1'b0, last_chunk_q}) && (!rd_vld_s1 || out_free);
				out_load = rd_vld_s1 && out_free;
				kind_nx  = KIND_TEXT;
				chunk_nx = chunk_word;
				tlen_nx  = text_len_q;
				last_nx  = (rd_word_s1 == last_chunk_q);
			end
			ST_CLOCK: begin
				out_load = out_free;
				kind_nx  = KIND_CLOCK;
				day_nx   = clk_day;
				hm_nx    = clk_hm;
				zone_nx  = clk_zone;
				last_nx  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer state and scan/emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_k_q     <= '0;
			emit_k_q     <= '0;
			rd_vld_s1    <= 1'b0;
			emit_text_q  <= 1'b0;
			text_len_q   <= '0;
			last_chunk_q <= '0;
		end else begin
			state_q <= state_nx;
			if (acc) begin
				scan_k_q    <= '0;
				emit_k_q    <= '0;
				emit_text_q <= 1'b0;
			end else begin
				if ((state_q == ST_SCAN) && rd_en) scan_k_q <= scan_k_q + 1'b1;
				if ((state_q == ST_EMIT) && rd_en) emit_k_q <= emit_k_q + 1'b1;
			end
			// a pending scan read is dropped when the scan ends
			if (scan_done)                            rd_vld_s1 <= 1'b0;
			else if (rd_en)                           rd_vld_s1 <= 1'b1;
			else if (out_load && state_q == ST_EMIT)  rd_vld_s1 <= 1'b0;
			if (scan_done) begin
				emit_text_q  <= cr_any || end_full;
				text_len_q   <= len_nx;
				last_chunk_q <= (len_nx == 7'd0) ? '0 : len_m1[WORD_AW+1:2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_word_s1 <= rd_word;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q     <= kind_nx;
			pi_out_q   <= pi_q;
			pty_q      <= bb_q[9:5];
			sflags_q   <= {bb_q[10], ta_q, music_q};
			name_out_q <= name_flat;
			chunk_q    <= chunk_nx;
			tlen_q     <= tlen_nx;
			day_q      <= day_nx;
			hm_q       <= hm_nx;
			zone_q     <= zone_nx;
			last_q     <= last_nx;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.kind         = kind_q;
	assign res.pi_code      = pi_out_q;
	assign res.program_type = pty_q;
	assign res.status_flags = sflags_q;
	assign res.station_name = name_out_q;
	assign res.text_chunk   = chunk_q;
	assign res.text_length  = tlen_q;
	assign res.day_number   = day_q;
	assign res.hour_minute  = hm_q;
	assign res.zone_offset  = zone_q;
	assign res.last         = last_q;

	// checks
	a_chunk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && rd_vld_s1) |-> (rd_word_s1 <= last_chunk_q))
		else $error("chunk read beyond message end");

	a_scan_no_text_yet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !emit_text_q)
		else $error("text flagged before scan finished");

	a_text_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit_text_q |-> (text_len_q <= FULL_LEN))
		else $error("text length beyond store size");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !res.ready) |=> ($stable(kind_q) && $stable(last_q)))
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

>>> test/tb.sv
// testbench of rds_group_decoder: random and directed groups checked against a predictor
`timescale 1ns / 100ps

module tb;
	import rdsg_pkg::*;

	localparam int GROUPS      = 330;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 40;

	// one decoded result as seen on the output channel
	typedef struct {
		logic [1:0]         kind;
		logic [15:0]        pi_code;
		logic [4:0]         program_type;
		logic [2:0]         status_flags;
		logic [63:0]        station_name;
		logic [31:0]        text_chunk;
		logic [6:0]         text_length;
		logic [16:0]        day_number;
		logic [10:0]        hour_minute;
		logic signed [10:0] zone_offset;
		logic               last;
	} rds_result_t;

	// decoder state mirror and queue of results still owed by the block
	class group_predictor;
		bit          ta_flag;
		bit          music;
		bit          ab_flag;
		logic [7:0]  name_bytes[8];
		logic [7:0]  text_bytes[TEXT_BYTES];
		rds_result_t pending[$];
		int          errors;

		function new();
			ta_flag = 1'b0;
			music   = 1'b1;
			ab_flag = 1'b0;
			foreach (name_bytes[i]) name_bytes[i] = 8'h00;
			foreach (text_bytes[i]) text_bytes[i] = 8'h00;
			errors = 0;
		endfunction

		// update the state for one accepted group request and queue its results
		function void note_group(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d);
			logic [3:0]  gtype;
			logic        ver_b;
			int          p;
			int          fin;
			int          cr;
			int          text_len;
			int          chunks;
			int          idx;
			bit          emit_text;
			bit          emit_time;
			logic [4:0]  hour;
			logic [5:0]  minute;
			logic [10:0] zmag;
			logic [31:0] w;
			logic [63:0] name;
			rds_result_t base;
			rds_result_t r;

			gtype     = b[15:12];
			ver_b     = b[11];
			emit_text = 0;
			emit_time = 0;
			text_len  = 0;
			fin       = 0;
			base      = '{default: 0};

			if (gtype == GT_NAME) begin
				p = int'(b[1:0]) * 2;
				ta_flag = b[4];
				music   = b[3];
				name_bytes[p]     = d[15:8];
				name_bytes[p + 1] = d[7:0];
			end else if (gtype == GT_TEXT) begin
				// a flipped a/b flag starts a new message
				if (b[4] != ab_flag) begin
					foreach (text_bytes[i]) text_bytes[i] = 8'h00;
					ab_flag = b[4];
				end
				if (!ver_b) begin
					p = int'(b[3:0]) * 4;
					text_bytes[p]     = c[15:8];
					text_bytes[p + 1] = c[7:0];
					text_bytes[p + 2] = d[15:8];
					text_bytes[p + 3] = d[7:0];
					fin = p + 4;
				end else begin
					p = int'(b[3:0]) * 2;
					text_bytes[p]     = d[15:8];
					text_bytes[p + 1] = d[7:0];
					fin = p + 2;
				end
				cr = -1;
				for (int i = 0; i < TEXT_BYTES; i++) begin
					if (cr < 0 && text_bytes[i] == CR_CHAR) cr = i;
				end
				if (cr >= 0) begin
					emit_text = 1;
					text_len  = cr;
				end else if (fin >= TEXT_BYTES) begin
					emit_text = 1;
					text_len  = TEXT_BYTES;
				end
			end else if (gtype == GT_CLOCK && !ver_b) begin
				emit_time = 1;
				hour   = {c[0], d[15:12]};
				minute = {d[11:8], d[7:6]};
				zmag   = 11'(int'(d[4:0]) * ZONE_STEP);
				base.day_number  = {b[1:0], c[15:1]};
				base.hour_minute = {hour, minute};
				base.zone_offset = d[5] ? -zmag : zmag;
			end

			name = 64'h0;
			for (int i = 0; i < 8; i++) name = {name[55:0], name_bytes[i]};

			// status result, always first
			r = '{default: 0};
			r.kind         = KIND_STATUS;
			r.pi_code      = a;
			r.program_type = b[9:5];
			r.status_flags = {b[10], ta_flag, music};
			r.station_name = name;
			pending.push_back(r);

			// radiotext chunks, one empty chunk for an empty message
			if (emit_text) begin
				chunks = (text_len + 3) / 4;
				if (chunks == 0) chunks = 1;
				for (int k = 0; k < chunks; k++) begin
					w = 32'h0;
					for (int j = 0; j < 4; j++) begin
						idx = k * 4 + j;
						w = {w[23:0], (idx < text_len) ? text_bytes[idx] : 8'h00};
					end
					r.kind        = KIND_TEXT;
					r.text_chunk  = w;
					r.text_length = 7'(text_len);
					pending.push_back(r);
				end
			end

			// clock time result
			if (emit_time) begin
				r.kind        = KIND_CLOCK;
				r.text_chunk  = 32'h0;
				r.text_length = 7'h0;
				r.day_number  = base.day_number;
				r.hour_minute = base.hour_minute;
				r.zone_offset = base.zone_offset;
				pending.push_back(r);
			end
			pending[pending.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string fname, logic [63:0] got, logic [63:0] want);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
			end
		endfunction

		// compare one accepted result with the oldest one owed
		function void check_result(rds_result_t got);
			rds_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, kind expected none actual %0d pi %h",
					$time, got.kind, got.pi_code);
				return;
			end
			want = pending.pop_front();
			compare_field("kind", got.kind, want.kind);
			compare_field("pi_code", got.pi_code, want.pi_code);
			compare_field("program_type", got.program_type, want.program_type);
			compare_field("status_flags", got.status_flags, want.status_flags);
			compare_field("station_name", got.station_name, want.station_name);
			compare_field("text_chunk", got.text_chunk, want.text_chunk);
			compare_field("text_length", got.text_length, want.text_length);
			compare_field("day_number", got.day_number, want.day_number);
			compare_field("hour_minute", got.hour_minute, want.hour_minute);
			compare_field("zone_offset", got.zone_offset, want.zone_offset);
			compare_field("last", got.last, want.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   sent;
	int   tx_quiet;
	int   rx_quiet;

	group_predictor pred = new();

	rdsg_grp_if grp();
	rdsg_res_if res();

	rds_group_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.grp    (grp),
		.res    (res)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// idle cycles before the next request, with runs of back-to-back traffic
	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(5, 20);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	function automatic logic [15:0] pack_b(logic [3:0] gtype, logic ver, logic tp,
		logic [4:0] pty, logic [4:0] flags);
		return {gtype, ver, tp, pty, flags};
	endfunction

	// any text byte but the carriage return
	function automatic logic [7:0] text_char();
		logic [7:0] v;
		v = 8'($urandom);
		if (v == CR_CHAR) v = 8'h20;
		return v;
	endfunction

	// present one group and hold it until it is taken
	task automatic send_group(logic [15:0] a, logic [15:0] b, logic [15:0] c,
		logic [15:0] d);
		int gap;
		gap = draw_wait(tx_quiet);
		if (gap > 0) begin
			grp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		grp.valid   <= 1'b1;
		grp.block_a <= a;
		grp.block_b <= b;
		grp.block_c <= c;
		grp.block_d <= d;
		do @(posedge clk); while (!grp.ready);
		pred.note_group(a, b, c, d);
		sent++;
	endtask

	// stop sending until every owed result has arrived
	task automatic wait_drain();
		grp.valid <= 1'b0;
		do @(posedge clk); while (pred.pending.size() != 0);
	endtask

	// result side: random stalls, check each accepted result
	initial begin
		int          stall;
		rds_result_t got;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(rx_quiet);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			got.kind         = res.kind;
			got.pi_code      = res.pi_code;
			got.program_type = res.program_type;
			got.status_flags = res.status_flags;
			got.station_name = res.station_name;
			got.text_chunk   = res.text_chunk;
			got.text_length  = res.text_length;
			got.day_number   = res.day_number;
			got.hour_minute  = res.hour_minute;
			got.zone_offset  = res.zone_offset;
			got.last         = res.last;
			pred.check_result(got);
		end
	end

	// stimulus
	initial begin
		int          pick;
		int          mlen;
		int          nseg;
		bit          drained;
		logic        ab_sel;
		logic        ver;
		logic        tp;
		logic [4:0]  pty;
		logic [15:0] pi;
		logic [7:0]  msg[TEXT_BYTES];

		cycles   = 0;
		sent     = 0;
		tx_quiet = 0;
		rx_quiet = 0;
		drained  = 0;
		arst_n      <= 1'b0;
		grp.valid   <= 1'b0;
		grp.block_a <= 16'h0;
		grp.block_b <= 16'h0;
		grp.block_c <= 16'h0;
		grp.block_d <= 16'h0;
		res.ready   <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// status only: reset flags, then all ones on an unhandled type
		send_group(16'h0000, pack_b(4'h1, 0, 0, 5'd0, 5'd0), 16'h0000, 16'h0000);
		send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// station name over all four positions, both versions
		send_group(16'h5A5A, pack_b(GT_NAME, 0, 1, 5'd10, 5'b10000), 16'h1111, 16'h5241);
		send_group(16'h5A5A, pack_b(GT_NAME, 1, 0, 5'd21, 5'b01101), 16'h2222, 16'h4449);
		send_group(16'h5A5A, pack_b(GT_NAME, 0, 1, 5'd31, 5'b11010), 16'h3333, 16'h4F20);
		send_group(16'h5A5A, pack_b(GT_NAME, 1, 1, 5'd0, 5'b00111), 16'h4444, 16'hFF00);
		// clock time: all ones with negative zone, all zeros, positive zone, then 4b
		send_group(16'h1234, pack_b(GT_CLOCK, 0, 1, 5'd31, 5'b00011), 16'hFFFF, 16'hFFFF);
		send_group(16'h1234, pack_b(GT_CLOCK, 0, 0, 5'd0, 5'b00000), 16'h0000, 16'h0000);
		send_group(16'h1234, pack_b(GT_CLOCK, 0, 0, 5'd7, 5'b00001), 16'hAAAA, 16'h5A1F);
		send_group(16'h1234, pack_b(GT_CLOCK, 1, 0, 5'd3, 5'b00010), 16'h1234, 16'h5678);
		// radiotext: full store without cr, then a cr inside
		send_group(16'hC0DE, pack_b(GT_TEXT, 0, 0, 5'd1, 5'h00), 16'h4142, 16'h4344);
		send_group(16'hC0DE, pack_b(GT_TEXT, 0, 0, 5'd1, 5'h0F), 16'h5859, 16'h5A21);
		send_group(16'hC0DE, pack_b(GT_TEXT, 0, 0, 5'd1, 5'h01), 16'h450D, 16'h4647);
		// a/b flip clears; cr at byte zero gives the empty message
		send_group(16'hC0DE, pack_b(GT_TEXT, 1, 1, 5'd2, 5'h10), 16'hBEEF, 16'h0D41);
		send_group(16'hC0DE, pack_b(GT_TEXT, 1, 1, 5'd2, 5'h1F), 16'hBEEF, 16'h7E7F);
		send_group(16'hC0DE, pack_b(GT_TEXT, 0, 0, 5'd3, 5'h00), 16'h4869, 16'h210D);
		send_group(16'hC0DE, pack_b(GT_TEXT, 1, 0, 5'd3, 5'h01), 16'h0000, 16'h2020);
		wait_drain();

		// random part: mostly whole messages and name series, some noise
		while (sent < GROUPS) begin
			if (!drained && sent >= GROUPS / 2) begin
				wait_drain();
				drained = 1;
			end
			pick = $urandom_range(0, 9);
			pi   = 16'($urandom);
			tp   = 1'($urandom);
			pty  = 5'($urandom);
			case (pick)
				0, 1, 2, 3: begin
					// one radiotext message, segments in order, now and then one dropped
					ab_sel = 1'($urandom);
					ver    = ($urandom_range(0, 3) == 0);
					mlen   = ver ? $urandom_range(0, 31) : $urandom_range(0, TEXT_BYTES);
					for (int i = 0; i < TEXT_BYTES; i++) begin
						msg[i] = (i == mlen) ? CR_CHAR : text_char();
					end
					if (ver) nseg = mlen / 2 + 1;
					else nseg = (mlen < TEXT_BYTES) ? mlen / 4 + 1 : TEXT_WORDS;
					for (int s = 0; s < nseg; s++) begin
						if ($urandom_range(0, 9) == 0) continue;
						if (ver) begin
							send_group(pi, pack_b(GT_TEXT, 1, tp, pty, {ab_sel, 4'(s)}),
								16'($urandom), {msg[2 * s], msg[2 * s + 1]});
						end else begin
							send_group(pi, pack_b(GT_TEXT, 0, tp, pty, {ab_sel, 4'(s)}),
								{msg[4 * s], msg[4 * s + 1]}, {msg[4 * s + 2], msg[4 * s + 3]});
						end
					end
				end
				4, 5: begin
					// full station name
					ver = 1'($urandom);
					for (int s = 0; s < 4; s++) begin
						send_group(pi, pack_b(GT_NAME, ver, tp, pty, {3'($urandom), 2'(s)}),
							16'($urandom), 16'($urandom));
					end
				end
				6, 7: begin
					send_group(pi, pack_b(GT_CLOCK, $urandom_range(0, 5) == 0, tp, pty,
						5'($urandom)), 16'($urandom), 16'($urandom));
				end
				default: begin
					send_group(pi, 16'($urandom), 16'($urandom), 16'($urandom));
				end
			endcase
		end

		wait_drain();
		repeat (SETTLE) @(posedge clk);
		if (pred.errors == 0 && pred.pending.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

>>> rds_group_decoder.f
rtl/rdsg_pkg.sv
rtl/rdsg_if.sv
rtl/rdsg_text_store.sv
rtl/rdsg_clock_unpack.sv
rtl/rds_group_decoder.sv
test/tb.sv
